// ===== src/nbtc_pkg.sv =====
// Shared types, constants and helper functions for the token classifier.
package nbtc_pkg;

    localparam int KEY_BYTES = 63;
    localparam int NUM_KEYS  = 256;
    localparam int IDX_W     = 8;
    localparam int CNT_W     = 9;
    localparam int LEN_W     = 6;
    localparam int KADDR_W   = IDX_W + LEN_W;

    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_KEY    = 2'd1;
    localparam logic [1:0] REQ_COMMIT = 2'd2;
    localparam logic [1:0] REQ_CLASS  = 2'd3;

    localparam logic [1:0] ST_CLASSIFIED = 2'd0;
    localparam logic [1:0] ST_ADDED      = 2'd1;
    localparam logic [1:0] ST_DUPLICATE  = 2'd2;
    localparam logic [1:0] ST_FULL       = 2'd3;

    localparam logic signed [15:0] LOG_ZERO = 16'sh8000;
    localparam logic signed [15:0] LOG_MAX  = 16'sh7FFF;

    // controller -> datapath
    typedef struct packed {
        logic       accept;
        logic       srch_start;
        logic       src_tok;
        logic       idx_inc;
        logic       pos_inc;
        logic       hit_acc;
        logic       tok_clr;
        logic       copy_wr;
        logic       commit;
        logic       pend_clr;
        logic       out_load;
        logic [1:0] status;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] req;
        logic       fin;
        logic       last;
        logic       idx_end;
        logic       len_eq;
        logic       tgt_zero;
        logic       byte_eq;
        logic       pos_last;
        logic       full;
        logic       copy_done;
        logic       out_free;
    } t_dp_stat;

    // Saturating add in the log domain; the zero code is sticky.
    function automatic logic signed [15:0] log_add(input logic signed [15:0] a,
                                                   input logic signed [15:0] b);
        logic signed [16:0] s;
        s = 17'(a) + 17'(b);
        if (a == LOG_ZERO || b == LOG_ZERO)
            return LOG_ZERO;
        else if (s < 17'(LOG_ZERO))
            return LOG_ZERO;
        else if (s > 17'(LOG_MAX))
            return LOG_MAX;
        else
            return s[15:0];
    endfunction

    function automatic logic is_tok_char(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
               (c >= "0" && c <= "9") || (c == "%");
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

endpackage

// ===== src/nbtc_ctrl.sv =====
// Sequencer for the token classifier: decode, table search, key copy, result.
module nbtc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  nbtc_pkg::t_dp_stat  i_stat,
    output nbtc_pkg::t_dp_cmd   o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_SRCH   = 3'd2;
    localparam logic [2:0] S_CMP    = 3'd3;
    localparam logic [2:0] S_COPY   = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    logic [2:0] r_state, n_state;
    logic [1:0] r_status, n_status;
    logic       hit, miss;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        o_cmd    = '0;
        o_cmd.status = r_status;
        hit  = 1'b0;
        miss = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DECIDE;
                end
            end
            S_DECIDE: begin
                case (i_stat.req)
                    nbtc_pkg::REQ_COMMIT: begin
                        o_cmd.srch_start = 1'b1;
                        n_state          = S_SRCH;
                    end
                    nbtc_pkg::REQ_CLASS: begin
                        if (i_stat.fin) begin
                            o_cmd.srch_start = 1'b1;
                            o_cmd.src_tok    = 1'b1;
                            n_state          = S_SRCH;
                        end else if (i_stat.last) begin
                            n_status = nbtc_pkg::ST_CLASSIFIED;
                            n_state  = S_RESULT;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_SRCH: begin
                if (i_stat.idx_end)
                    miss = 1'b1;
                else if (!i_stat.len_eq)
                    o_cmd.idx_inc = 1'b1;
                else if (i_stat.tgt_zero)
                    hit = 1'b1;
                else
                    n_state = S_CMP;
            end
            S_CMP: begin
                if (!i_stat.byte_eq) begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SRCH;
                end else if (i_stat.pos_last) begin
                    hit = 1'b1;
                end else begin
                    o_cmd.pos_inc = 1'b1;
                end
            end
            S_COPY: begin
                if (i_stat.copy_done) begin
                    o_cmd.commit = 1'b1;
                    n_status     = nbtc_pkg::ST_ADDED;
                    n_state      = S_RESULT;
                end else begin
                    o_cmd.copy_wr = 1'b1;
                    o_cmd.pos_inc = 1'b1;
                end
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.pend_clr = (i_stat.req == nbtc_pkg::REQ_COMMIT);
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (hit || miss) begin
            if (i_stat.req == nbtc_pkg::REQ_COMMIT) begin
                if (hit) begin
                    n_status = nbtc_pkg::ST_DUPLICATE;
                    n_state  = S_RESULT;
                end else if (i_stat.full) begin
                    n_status = nbtc_pkg::ST_FULL;
                    n_state  = S_RESULT;
                end else begin
                    // restart position counter for the copy sweep
                    o_cmd.srch_start = 1'b1;
                    n_state          = S_COPY;
                end
            end else begin
                o_cmd.hit_acc = hit;
                o_cmd.tok_clr = 1'b1;
                if (i_stat.last) begin
                    n_status = nbtc_pkg::ST_CLASSIFIED;
                    n_state  = S_RESULT;
                end else begin
                    n_state = S_IDLE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= nbtc_pkg::ST_CLASSIFIED;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

endmodule

// ===== src/nbtc_dp.sv =====
// Datapath: key table memories, token and pending-key buffers, sums, output register.
module nbtc_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nbtc_pkg::t_dp_cmd  i_cmd,
    output nbtc_pkg::t_dp_stat o_stat,
    input  logic [1:0]         i_req,
    input  logic [7:0]         i_byte,
    input  logic [15:0]        i_pos_log,
    input  logic [15:0]        i_neg_log,
    input  logic               i_last,
    input  logic               i_cfg_we,
    input  logic               i_cfg_addr,
    input  logic [15:0]        i_cfg_wdata,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_verdict,
    output logic [1:0]         o_status
);

    logic [7:0]  key_mem  [2**nbtc_pkg::KADDR_W];
    logic [nbtc_pkg::LEN_W-1:0] len_mem [nbtc_pkg::NUM_KEYS];
    logic [15:0] plog_mem [nbtc_pkg::NUM_KEYS];
    logic [15:0] nlog_mem [nbtc_pkg::NUM_KEYS];
    logic [7:0]  pend_mem [nbtc_pkg::KEY_BYTES];
    logic [7:0]  tok_mem  [nbtc_pkg::KEY_BYTES];

    logic signed [15:0] r_prior_p, r_prior_n;
    logic signed [15:0] r_psum, r_nsum;
    logic [15:0] r_plog_in, r_nlog_in;
    logic [1:0]  r_req;
    logic        r_last, r_fin, r_open;
    logic [nbtc_pkg::CNT_W-1:0] r_count;
    logic [nbtc_pkg::LEN_W-1:0] r_plen, r_tlen;
    logic [nbtc_pkg::CNT_W-1:0] r_idx, n_idx;
    logic [nbtc_pkg::LEN_W-1:0] r_pos, n_pos;
    logic        r_src, n_src;

    logic [nbtc_pkg::LEN_W-1:0] rd_len;
    logic [15:0] rd_plog, rd_nlog;
    logic [7:0]  rd_key, rd_src;

    logic [nbtc_pkg::LEN_W-1:0] base_len, target;
    logic [7:0]  c_low;
    logic        c_tok;

    logic        r_out_valid, r_verdict;
    logic [1:0]  r_status;

    assign c_low    = nbtc_pkg::to_lower(i_byte);
    assign c_tok    = nbtc_pkg::is_tok_char(i_byte);
    assign base_len = r_open ? r_tlen : '0;
    assign target   = r_src ? r_tlen : r_plen;

    always_comb begin
        n_idx = r_idx;
        n_pos = r_pos;
        n_src = r_src;
        if (i_cmd.srch_start) begin
            n_idx = '0;
            n_pos = '0;
            n_src = i_cmd.src_tok;
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + 1'b1;
            n_pos = '0;
        end else if (i_cmd.pos_inc) begin
            n_pos = r_pos + 1'b1;
        end
    end

    // memories: registered reads follow the next search pointers
    always_ff @(posedge i_clk) begin
        rd_len  <= len_mem[n_idx[nbtc_pkg::IDX_W-1:0]];
        rd_plog <= plog_mem[n_idx[nbtc_pkg::IDX_W-1:0]];
        rd_nlog <= nlog_mem[n_idx[nbtc_pkg::IDX_W-1:0]];
        rd_key  <= key_mem[{n_idx[nbtc_pkg::IDX_W-1:0], n_pos}];
        rd_src  <= n_src ? tok_mem[n_pos] : pend_mem[n_pos];
        if (i_cmd.copy_wr)
            key_mem[{r_count[nbtc_pkg::IDX_W-1:0], r_pos}] <= rd_src;
        if (i_cmd.commit) begin
            len_mem[r_count[nbtc_pkg::IDX_W-1:0]]  <= r_plen;
            plog_mem[r_count[nbtc_pkg::IDX_W-1:0]] <= r_plog_in;
            nlog_mem[r_count[nbtc_pkg::IDX_W-1:0]] <= r_nlog_in;
        end
        if (i_cmd.accept && i_req == nbtc_pkg::REQ_KEY &&
            r_plen != nbtc_pkg::LEN_W'(nbtc_pkg::KEY_BYTES))
            pend_mem[r_plen] <= i_byte;
        if (i_cmd.accept && i_req == nbtc_pkg::REQ_CLASS && c_tok)
            tok_mem[base_len] <= c_low;
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_pos <= n_pos;
        r_src <= n_src;
        if (i_cmd.accept) begin
            r_req     <= i_req;
            r_last    <= i_last;
            r_plog_in <= i_pos_log;
            r_nlog_in <= i_neg_log;
            r_fin     <= c_tok ? (base_len == nbtc_pkg::LEN_W'(nbtc_pkg::KEY_BYTES - 1) || i_last)
                               : (base_len != '0);
        end
        if (i_cmd.out_load) begin
            r_status  <= i_cmd.status;
            r_verdict <= (i_cmd.status == nbtc_pkg::ST_CLASSIFIED) && (r_psum > r_nsum);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior_p   <= -16'sd256;
            r_prior_n   <= -16'sd256;
            r_psum      <= -16'sd256;
            r_nsum      <= -16'sd256;
            r_count     <= '0;
            r_plen      <= '0;
            r_tlen      <= '0;
            r_open      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr) r_prior_n <= i_cfg_wdata;
                else            r_prior_p <= i_cfg_wdata;
            end
            if (i_cmd.accept) begin
                case (i_req)
                    nbtc_pkg::REQ_CLEAR: begin
                        r_count <= '0;
                        r_plen  <= '0;
                    end
                    nbtc_pkg::REQ_KEY: begin
                        if (r_plen != nbtc_pkg::LEN_W'(nbtc_pkg::KEY_BYTES))
                            r_plen <= r_plen + 1'b1;
                    end
                    nbtc_pkg::REQ_CLASS: begin
                        if (!r_open) begin
                            r_psum <= r_prior_p;
                            r_nsum <= r_prior_n;
                        end
                        r_open <= 1'b1;
                        r_tlen <= c_tok ? base_len + 1'b1 : base_len;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.hit_acc) begin
                r_psum <= nbtc_pkg::log_add(r_psum, rd_plog);
                r_nsum <= nbtc_pkg::log_add(r_nsum, rd_nlog);
            end
            if (i_cmd.tok_clr)
                r_tlen <= '0;
            if (i_cmd.commit)
                r_count <= r_count + 1'b1;
            if (i_cmd.pend_clr)
                r_plen <= '0;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
                if (r_req == nbtc_pkg::REQ_CLASS)
                    r_open <= 1'b0;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.req       = r_req;
    assign o_stat.fin       = r_fin;
    assign o_stat.last      = r_last;
    assign o_stat.idx_end   = (r_idx == r_count);
    assign o_stat.len_eq    = (rd_len == target);
    assign o_stat.tgt_zero  = (target == '0);
    assign o_stat.byte_eq   = (rd_key == rd_src);
    assign o_stat.pos_last  = (r_pos == target - 1'b1);
    assign o_stat.full      = (r_count == nbtc_pkg::CNT_W'(nbtc_pkg::NUM_KEYS));
    assign o_stat.copy_done = (r_pos == r_plen);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_verdict;
    assign o_status    = r_status;

endmodule

// ===== src/naive_bayes_token_classifier_unit.sv =====
// Top level of the naive Bayes token classifier.
//
//  channel   dir  signals                                  contents
//  s_axis    in   tvalid/tready/tdata[39:0]/tuser/tlast   request byte and key logs
//  m_axis    out  tvalid/tready/tdata[7:0]/tuser          verdict and status
//  cfg       in   i_cfg_we/i_cfg_addr/i_cfg_wdata          prior log registers
//
//  Key byte and clear requests, and a classify byte that closes no token, go from IDLE
//  through DECIDE back to IDLE; a classify byte with tlast goes on to RESULT. A token
//  end or commit walks the stored keys in order until a hit or the table end, comparing
//  bytes only on keys of equal length; an add copies the key at one byte per cycle.
//  Reset is synchronous, active low; the table needs no clearing pass.
//  The output register lets a new item in while a result waits to be taken.
module naive_bayes_token_classifier_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // data_byte[7:0], pos_log[23:8], neg_log[39:24]
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // verdict[0], zeros above
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);

    nbtc_pkg::t_dp_cmd  cmd;
    nbtc_pkg::t_dp_stat stat;
    logic               verdict;

    nbtc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    nbtc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_req       (s_axis_tuser),
        .i_byte      (s_axis_tdata[7:0]),
        .i_pos_log   (s_axis_tdata[23:8]),
        .i_neg_log   (s_axis_tdata[39:24]),
        .i_last      (s_axis_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_verdict   (verdict),
        .o_status    (m_axis_tuser)
    );

    assign m_axis_tdata = {7'd0, verdict};

endmodule

// ===== src/nbtc_chk.sv =====
// Port-level checker for the token classifier, bound to the top level.
module nbtc_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [1:0] m_axis_tuser
);

    a_rst_idle: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != nbtc_pkg::ST_CLASSIFIED |-> m_axis_tdata == 8'd0)
        else $error("verdict set on table result");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result one cycle after transfer");

endmodule

bind naive_bayes_token_classifier_unit nbtc_chk u_nbtc_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
